/* rtl/cdq_pkg.sv */
package cdq_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int OCC_W    = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SIZE       = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [POS_W-1:0]          found_position;
    logic [OCC_W-1:0]          occupancy;
  } cdq_result_t;

endpackage

/* rtl/cdq_if.sv */
interface cdq_in_if;
  logic                               valid;
  logic                               ready;
  logic [cdq_pkg::KIND_W-1:0]         kind;
  logic signed [cdq_pkg::VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface cdq_out_if;
  logic                               valid;
  logic                               ready;
  logic [cdq_pkg::STATUS_W-1:0]       status;
  logic signed [cdq_pkg::VALUE_W-1:0] removed_value;
  logic [cdq_pkg::POS_W-1:0]          found_position;
  logic [cdq_pkg::OCC_W-1:0]          occupancy;

  modport source (output valid, status, removed_value, found_position, occupancy,
                  input ready);
  modport sink   (input valid, status, removed_value, found_position, occupancy,
                  output ready);
endinterface

/* rtl/circular_deque_with_search.sv */
// Flow: push, size report and refused operations go from acceptance into the result
//   register or skid entry; a pop passes through S_POP for its one memory read; a search
//   steps through S_SRCH, one entry per step, until a match or the last occupied entry.
// No new transaction is taken before the last result is emitted; one read per search step.
// Reset (rst, synchronous): clears front index, entry count and handshake state at once;
//   the ring store is not cleared, only entries inside the occupied window are used.
module circular_deque_with_search #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);

  // index and count widths
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [IW:0]   DEPTH_S = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_I  = IW'(DEPTH - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  // ring position of offset 'off' from 'base'; sum stays below 2*DEPTH
  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [IW:0] sum;
    sum = (IW + 1)'(base) + (IW + 1)'(off);
    if (sum >= DEPTH_S) sum = sum - DEPTH_S;
    return sum[IW-1:0];
  endfunction

  function automatic logic [cdq_pkg::OCC_W-1:0] occ_field(logic [CW-1:0] c);
    logic [63:0] t;
    t = 64'(c);
    return t[cdq_pkg::OCC_W-1:0];
  endfunction

  function automatic logic [cdq_pkg::POS_W-1:0] pos_field(logic [IW-1:0] p);
    logic [63:0] t;
    t = 64'(p);
    return t[cdq_pkg::POS_W-1:0];
  endfunction

  // ring store: one write port, one registered read port
  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata;
  logic [IW-1:0]         raddr;
  logic [IW-1:0]         waddr;
  logic                  wr_en;

  // control state
  logic [1:0]            state, state_next;
  logic [IW-1:0]         front, front_next;
  logic [CW-1:0]         count, count_next;
  logic [IW-1:0]         rd_pos, rd_pos_next;
  logic [WORD_WIDTH-1:0] key, key_next;

  // result register plus one skid entry
  cdq_pkg::cdq_result_t  out_res, hold_res, emit_res;
  logic                  out_valid, hold_valid, emit, out_free;

  logic                  in_ready, acc;
  logic [CW-1:0]         off;
  logic [IW-1:0]         front_dec;
  logic [63:0]           value64, rdata64;
  logic [WORD_WIDTH-1:0] in_word;
  logic [cdq_pkg::VALUE_W-1:0] removed_word;
  logic                  is_full, is_empty;

  assign value64      = {32'd0, in_ch.value};
  assign in_word      = value64[WORD_WIDTH-1:0];
  assign rdata64      = 64'(rdata);
  assign removed_word = rdata64[cdq_pkg::VALUE_W-1:0];

  assign is_full   = (count == DEPTH_C);
  assign is_empty  = (count == '0);
  assign front_dec = (front == '0) ? LAST_I : front - IW'(1);

  // a new transaction is taken only in idle and while the skid entry is free,
  // so every result produced has a register to land in
  assign in_ready    = (state == S_IDLE) && !hold_valid;
  assign acc         = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign raddr = wrap_add(front, off);

  always_comb begin
    state_next  = state;
    front_next  = front;
    count_next  = count;
    rd_pos_next = rd_pos;
    key_next    = key;
    off         = '0;
    wr_en       = 1'b0;
    waddr       = raddr;
    emit        = 1'b0;
    emit_res    = '0;
    emit_res.status    = cdq_pkg::STATUS_OK;
    emit_res.occupancy = occ_field(count);

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (in_ch.kind)
            cdq_pkg::KIND_PUSH_FRONT: begin
              emit = 1'b1;
              if (is_full) begin
                emit_res.status = cdq_pkg::STATUS_FULL;
              end else begin
                wr_en      = 1'b1;
                waddr      = front_dec;
                front_next = front_dec;
                count_next = count + CW'(1);
                emit_res.occupancy = occ_field(count + CW'(1));
              end
            end
            cdq_pkg::KIND_PUSH_BACK: begin
              emit = 1'b1;
              if (is_full) begin
                emit_res.status = cdq_pkg::STATUS_FULL;
              end else begin
                off        = count;
                wr_en      = 1'b1;
                count_next = count + CW'(1);
                emit_res.occupancy = occ_field(count + CW'(1));
              end
            end
            cdq_pkg::KIND_POP_FRONT: begin
              if (is_empty) begin
                emit            = 1'b1;
                emit_res.status = cdq_pkg::STATUS_EMPTY;
              end else begin
                // read uses the old front; the word arrives next cycle
                front_next = wrap_add(front, CW'(1));
                count_next = count - CW'(1);
                state_next = S_POP;
              end
            end
            cdq_pkg::KIND_POP_BACK: begin
              if (is_empty) begin
                emit            = 1'b1;
                emit_res.status = cdq_pkg::STATUS_EMPTY;
              end else begin
                off        = count - CW'(1);
                count_next = count - CW'(1);
                state_next = S_POP;
              end
            end
            cdq_pkg::KIND_SEARCH: begin
              if (is_empty) begin
                emit            = 1'b1;
                emit_res.status = cdq_pkg::STATUS_EMPTY;
              end else begin
                rd_pos_next = '0;
                key_next    = in_word;
                state_next  = S_SRCH;
              end
            end
            default: begin
              // size report, and the unused codes behave the same
              emit = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        emit = 1'b1;
        emit_res.removed_value = removed_word;
        state_next = S_IDLE;
      end
      S_SRCH: begin
        // rdata holds entry rd_pos; the read for rd_pos + 1 goes out now
        off = CW'(rd_pos) + CW'(1);
        if (rdata == key) begin
          emit = 1'b1;
          emit_res.found_position = pos_field(rd_pos);
          state_next = S_IDLE;
        end else if (CW'(rd_pos) == count - CW'(1)) begin
          emit = 1'b1;
          emit_res.status = cdq_pkg::STATUS_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          rd_pos_next = rd_pos + IW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= in_word;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos <= rd_pos_next;
    key    <= key_next;
  end

  // output side: the skid entry drains into the result register first
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= emit;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid) begin
        out_res  <= hold_res;
        hold_res <= emit_res;
      end else begin
        out_res <= emit_res;
      end
    end else if (emit) begin
      hold_res <= emit_res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_res.status;
  assign out_ch.removed_value  = out_res.removed_value;
  assign out_ch.found_position = out_res.found_position;
  assign out_ch.occupancy      = out_res.occupancy;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count exceeds depth");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> (CW'(rd_pos) < count))
    else $error("search walked past the occupied window");

  a_search_frozen: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |=> ($stable(front) && $stable(count)))
    else $error("ring pointers moved during a search");

endmodule

/* tb/tb_circular_deque_with_search.sv */
module tb_circular_deque_with_search;

  // Block configuration under test; the shadow deque below tracks the same sizes.
  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;

  localparam int CLK_PERIOD = 8;
  localparam int N_RANDOM   = 1800;
  localparam int TAIL_ITEMS = 200;   // final stretch runs with no idling on either side

  // Codes 6 and 7 are not defined operations; the block treats them as a size report.
  localparam logic [cdq_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [cdq_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  localparam logic signed [cdq_pkg::VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [cdq_pkg::VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

  // Random phase flavors: how the operation mix leans.
  localparam int MODE_MIXED  = 0;
  localparam int MODE_FILL   = 1;
  localparam int MODE_DRAIN  = 2;
  localparam int MODE_LOOKUP = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque_with_search #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Reset asserted from the start, released on a falling edge, never asserted again.
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(CLK_PERIOD * 1_000_000);
    $display("[circular_deque_with_search] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow deque: own copy of the ring, front index and entry count.
  // Updated once per accepted input transaction, in acceptance order.
  // ---------------------------------------------------------------------------
  logic signed [cdq_pkg::VALUE_W-1:0] shadow_ring [DEPTH];
  int                                 shadow_front = 0;
  int                                 shadow_count = 0;

  cdq_pkg::cdq_result_t expected_results [$];
  int                   mismatches = 0;

  // Set by the driver together with each transaction: a hand-typed result for
  // directed rows whose answer is obvious, otherwise the shadow deque decides.
  bit                   row_has_lit = 1'b0;
  cdq_pkg::cdq_result_t row_lit     = '0;

  // Idling knobs, changed per random phase.
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit quiet_tail = 1'b0;

  // Apply one operation to the shadow deque and return the result it should give.
  function automatic cdq_pkg::cdq_result_t apply_deque_op(
      logic [cdq_pkg::KIND_W-1:0] kind, logic signed [cdq_pkg::VALUE_W-1:0] value);
    cdq_pkg::cdq_result_t r;
    int                   k;
    r = '0;
    case (kind)
      cdq_pkg::KIND_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = cdq_pkg::STATUS_FULL;   // refused, word dropped
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_front] = value;
          shadow_count++;
        end
      end
      cdq_pkg::KIND_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = cdq_pkg::STATUS_FULL;
        end else begin
          shadow_ring[(shadow_front + shadow_count) % DEPTH] = value;
          shadow_count++;
        end
      end
      cdq_pkg::KIND_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = cdq_pkg::STATUS_EMPTY;
        end else begin
          r.removed_value = shadow_ring[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end
      end
      cdq_pkg::KIND_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = cdq_pkg::STATUS_EMPTY;
        end else begin
          r.removed_value = shadow_ring[(shadow_front + shadow_count - 1) % DEPTH];
          shadow_count--;
        end
      end
      cdq_pkg::KIND_SEARCH: begin
        if (shadow_count == 0) begin
          r.status = cdq_pkg::STATUS_EMPTY;
        end else begin
          // first match walking from the front; position stays zero on a miss
          r.status = cdq_pkg::STATUS_NOT_FOUND;
          for (k = 0; k < shadow_count; k++) begin
            if (shadow_ring[(shadow_front + k) % DEPTH] == value) begin
              r.status         = cdq_pkg::STATUS_OK;
              r.found_position = cdq_pkg::POS_W'(k);
              break;
            end
          end
        end
      end
      default: ;   // size report and spare codes: status ok, nothing moves
    endcase
    r.occupancy = cdq_pkg::OCC_W'(shadow_count);
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. Input side is handled
  // first so that a result in the same edge would still find its expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    cdq_pkg::cdq_result_t predicted;
    cdq_pkg::cdq_result_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = apply_deque_op(in_ch.kind, in_ch.value);
        expected_results.push_back(row_has_lit ? row_lit : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual %0h",
                   $time, {out_ch.status, out_ch.removed_value, out_ch.found_position,
                           out_ch.occupancy});
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status",         want.status,         out_ch.status);
          check_field("removed_value",  want.removed_value,  out_ch.removed_value);
          check_field("found_position", want.found_position, out_ch.found_position);
          check_field("occupancy",      want.occupancy,      out_ch.occupancy);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure: random stall bursts, driven at the falling
  // edge. Off entirely in the tail.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet_tail && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Send one transaction. Called on a falling edge; returns on the falling edge
  // after acceptance, so valid is written once per step (held high back to back
  // when no gap is drawn).
  task automatic send_op(input logic [cdq_pkg::KIND_W-1:0] kind,
                         input logic signed [cdq_pkg::VALUE_W-1:0] value,
                         input bit has_lit, input cdq_pkg::cdq_result_t lit);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 18);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    row_has_lit = has_lit;
    row_lit     = lit;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [cdq_pkg::KIND_W-1:0] pick_kind(int mode);
    int                         roll;
    logic [cdq_pkg::KIND_W-1:0] push_kind;
    logic [cdq_pkg::KIND_W-1:0] pop_kind;
    roll      = $urandom_range(0, 99);
    push_kind = ($urandom_range(0, 1) != 0) ? cdq_pkg::KIND_PUSH_FRONT
                                            : cdq_pkg::KIND_PUSH_BACK;
    pop_kind  = ($urandom_range(0, 1) != 0) ? cdq_pkg::KIND_POP_FRONT
                                            : cdq_pkg::KIND_POP_BACK;
    if (roll < 3) return ($urandom_range(0, 1) != 0) ? KIND_SPARE_6 : KIND_SPARE_7;
    if (roll < 8) return cdq_pkg::KIND_SIZE;
    case (mode)
      MODE_FILL:
        return (roll < 65) ? push_kind : (roll < 80) ? pop_kind : cdq_pkg::KIND_SEARCH;
      MODE_DRAIN:
        return (roll < 25) ? push_kind : (roll < 80) ? pop_kind : cdq_pkg::KIND_SEARCH;
      MODE_LOOKUP:
        return (roll < 35) ? push_kind : (roll < 50) ? pop_kind : cdq_pkg::KIND_SEARCH;
      default:
        return (roll < 45) ? push_kind : (roll < 75) ? pop_kind : cdq_pkg::KIND_SEARCH;
    endcase
  endfunction

  // Small values give duplicates; searches mostly aim at something held.
  function automatic logic signed [cdq_pkg::VALUE_W-1:0] pick_word(
      logic [cdq_pkg::KIND_W-1:0] kind);
    int roll;
    roll = $urandom_range(0, 99);
    if (kind == cdq_pkg::KIND_SEARCH && shadow_count > 0 && roll < 60)
      return shadow_ring[(shadow_front + $urandom_range(0, shadow_count - 1)) % DEPTH];
    if (roll < 40) return $urandom_range(0, 15) - 8;
    if (roll < 52) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MAX;
        1:       return WORD_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed rows. reps repeats a row, adding step to the word each time.
  // Rows with has_lit carry a typed result; the rest use the shadow deque.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [cdq_pkg::KIND_W-1:0]         kind;
    logic signed [cdq_pkg::VALUE_W-1:0] value;
    int                                 reps;
    int                                 step;
    bit                                 has_lit;
    cdq_pkg::cdq_result_t               lit;
  } op_row_t;

  localparam int N_DIRECTED = 24;

  op_row_t directed_ops [N_DIRECTED] = '{
    // fresh out of reset: empty store on every read-type op, spare codes
    '{cdq_pkg::KIND_SIZE,       32'sd0,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        32'sd0,   4'd0,  5'd0}},
    '{cdq_pkg::KIND_POP_FRONT,  32'sd0,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_EMPTY,     32'sd0,   4'd0,  5'd0}},
    '{cdq_pkg::KIND_POP_BACK,   32'sd0,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_EMPTY,     32'sd0,   4'd0,  5'd0}},
    '{cdq_pkg::KIND_SEARCH,     32'sd0,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_EMPTY,     32'sd0,   4'd0,  5'd0}},
    '{KIND_SPARE_6,             -32'sd1,  1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        32'sd0,   4'd0,  5'd0}},
    '{KIND_SPARE_7,             WORD_MAX, 1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        32'sd0,   4'd0,  5'd0}},
    // extreme words through both ends, front index wraps below zero
    '{cdq_pkg::KIND_PUSH_BACK,  WORD_MAX, 1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        32'sd0,   4'd0,  5'd1}},
    '{cdq_pkg::KIND_PUSH_FRONT, WORD_MIN, 1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        32'sd0,   4'd0,  5'd2}},
    '{cdq_pkg::KIND_SEARCH,     WORD_MAX, 1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        32'sd0,   4'd1,  5'd2}},
    '{cdq_pkg::KIND_SEARCH,     32'sd0,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_NOT_FOUND, 32'sd0,   4'd0,  5'd2}},
    '{cdq_pkg::KIND_POP_BACK,   32'sd0,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        WORD_MAX, 4'd0,  5'd1}},
    '{cdq_pkg::KIND_POP_FRONT,  32'sd0,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        WORD_MIN, 4'd0,  5'd0}},
    // duplicates: search must report the one nearest the front
    '{cdq_pkg::KIND_PUSH_FRONT, 32'sd3,   2, 0, 1'b0, '0},
    '{cdq_pkg::KIND_SEARCH,     32'sd3,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        32'sd0,   4'd0,  5'd2}},
    '{cdq_pkg::KIND_POP_BACK,   32'sd0,   2, 0, 1'b0, '0},
    // fill to the brim across the ring boundary, then refuse at both ends
    '{cdq_pkg::KIND_PUSH_BACK,  32'sd1,  16, 1, 1'b0, '0},
    '{cdq_pkg::KIND_PUSH_FRONT, 32'sd5,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_FULL,      32'sd0,   4'd0,  5'd16}},
    '{cdq_pkg::KIND_PUSH_BACK,  -32'sd5,  1, 0, 1'b1,
      '{cdq_pkg::STATUS_FULL,      32'sd0,   4'd0,  5'd16}},
    '{cdq_pkg::KIND_SEARCH,     32'sd16,  1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        32'sd0,   4'd15, 5'd16}},
    '{cdq_pkg::KIND_SEARCH,     -32'sd1,  1, 0, 1'b1,
      '{cdq_pkg::STATUS_NOT_FOUND, 32'sd0,   4'd0,  5'd16}},
    '{cdq_pkg::KIND_SIZE,       32'sd0,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_OK,        32'sd0,   4'd0,  5'd16}},
    // drain it; stale words left in the ring must not be seen
    '{cdq_pkg::KIND_POP_FRONT,  32'sd0,  16, 0, 1'b0, '0},
    '{cdq_pkg::KIND_POP_BACK,   32'sd0,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_EMPTY,     32'sd0,   4'd0,  5'd0}},
    '{cdq_pkg::KIND_SEARCH,     32'sd1,   1, 0, 1'b1,
      '{cdq_pkg::STATUS_EMPTY,     32'sd0,   4'd0,  5'd0}}
  };

  // ---------------------------------------------------------------------------
  // Stimulus: directed rows, then random phases, then wind down.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                                 items_sent;
    int                                 phase_len;
    int                                 mode;
    logic [cdq_pkg::KIND_W-1:0]         kind;
    logic signed [cdq_pkg::VALUE_W-1:0] word;

    in_ch.valid = 1'b0;
    in_ch.kind  = cdq_pkg::KIND_SIZE;
    in_ch.value = '0;

    wait (rst == 1'b0);
    @(negedge clk);

    // directed part: mild idling so gaps land on the early corner cases too
    idle_pct  = 10;
    stall_pct = 5;
    foreach (directed_ops[r]) begin
      for (int n = 0; n < directed_ops[r].reps; n++) begin
        send_op(directed_ops[r].kind, directed_ops[r].value + n * directed_ops[r].step,
                directed_ops[r].has_lit, directed_ops[r].lit);
      end
    end

    // random part: phases lean toward filling, draining or lookups, each with
    // its own idle and stall rates (zero included)
    items_sent = 0;
    while (items_sent < N_RANDOM) begin
      phase_len = $urandom_range(40, 160);
      mode      = $urandom_range(MODE_MIXED, MODE_LOOKUP);
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 4;
        2:       idle_pct = 12;
        default: idle_pct = 30;
      endcase
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 3;
        2:       stall_pct = 8;
        default: stall_pct = 20;
      endcase
      for (int i = 0; i < phase_len && items_sent < N_RANDOM; i++) begin
        if (items_sent >= N_RANDOM - TAIL_ITEMS) begin
          quiet_tail = 1'b1;
          idle_pct   = 0;
        end
        kind = pick_kind(mode);
        word = pick_word(kind);
        send_op(kind, word, 1'b0, '0);
        items_sent++;
      end
    end
    in_ch.valid <= 1'b0;

    // let every outstanding result arrive, then keep watching the result side
    // to catch any stray transaction
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("[circular_deque_with_search] OK");
    end else begin
      $display("[circular_deque_with_search] ERROR");
    end
    $finish;
  end

endmodule

/* circular_deque_with_search.f */
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/circular_deque_with_search.sv
tb/tb_circular_deque_with_search.sv
